FILE: rtl/battery_meter_display_encoder_macros.svh
// Assertion macros for the battery meter display encoder.
`ifndef BATTERY_METER_DISPLAY_ENCODER_MACROS_SVH
`define BATTERY_METER_DISPLAY_ENCODER_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BMDE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmde assertion failed");

// Condition must hold in the cycle after the trigger.
`define BMDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmde assertion failed");

`endif

FILE: rtl/bmde_pkg.sv
`timescale 1ns / 1ps

package bmde_pkg;

   typedef struct packed {
      logic signed [15:0] voltage_raw;
      logic [7:0]         status_byte;
   } req_type;

   typedef struct packed {
      logic [28:0] display_bits;
      logic        error;
   } rsp_type;

   // display word layout
   localparam int unsigned MARK_PCT   = 0;
   localparam int unsigned MARK_VOLT  = 1;
   localparam int unsigned MARK_DP    = 2;
   localparam int unsigned DIGIT_R_LSB = 3;
   localparam int unsigned DIGIT_M_LSB = 10;
   localparam int unsigned DIGIT_L_LSB = 17;
   localparam int unsigned BAR_LSB    = 24;
   localparam int unsigned PCT_MODE_BIT = 4;

   localparam logic [13:0] MV_OFFSET = 14'd3000;
   localparam logic [6:0]  PCT_MAX   = 7'd100;

   localparam logic [6:0] BAR_TH0 = 7'd5;
   localparam logic [6:0] BAR_TH1 = 7'd29;
   localparam logic [6:0] BAR_TH2 = 7'd49;
   localparam logic [6:0] BAR_TH3 = 7'd69;
   localparam logic [6:0] BAR_TH4 = 7'd89;

   // reciprocal multipliers: floor(x * RECIP >> SHIFT) is exact for 14-bit x
   localparam logic [15:0] RECIP10   = 16'd52429;  // >> 19
   localparam logic [12:0] RECIP100  = 13'd5243;   // >> 19
   localparam logic [14:0] RECIP1000 = 15'd16778;  // >> 24
   localparam logic [7:0]  RECIP10_PCT = 8'd205;   // >> 11, exact up to 100

   function automatic logic [6:0] seg7(input logic [3:0] digit);
      logic [6:0] pat;
      case (digit)
         4'd0: pat = 7'h3F;
         4'd1: pat = 7'h06;
         4'd2: pat = 7'h5B;
         4'd3: pat = 7'h4F;
         4'd4: pat = 7'h66;
         4'd5: pat = 7'h6D;
         4'd6: pat = 7'h7D;
         4'd7: pat = 7'h07;
         4'd8: pat = 7'h7F;
         4'd9: pat = 7'h6F;
         default: pat = 7'h00;
      endcase
      return pat;
   endfunction

endpackage

FILE: rtl/bmde_encode.sv
`timescale 1ns / 1ps

module bmde_encode (
   input  bmde_pkg::req_type item_i,
   output bmde_pkg::rsp_type item_o
);

   logic [13:0] mv;
   logic [29:0] p10;
   logic [26:0] p100;
   logic [28:0] p1000;
   logic [10:0] q10;
   logic [7:0]  q100;
   logic [4:0]  q1000;
   logic [3:0]  rem;
   logic [3:0]  r0, m0, l0, r1, m1, l1, vr, vm, vl;
   logic        carry_r, carry_m;
   logic [13:0] over;
   logic [10:0] over_sh;
   logic [6:0]  pct;
   logic [14:0] pq;
   logic [3:0]  pt, pr, pm;
   logic        pl;
   logic [28:0] disp;

   always_comb begin
      mv = item_i.voltage_raw[14:1];

      // volts digits from parallel reciprocal multiplies
      p10   = 30'(mv) * 30'(bmde_pkg::RECIP10);
      p100  = 27'(mv) * 27'(bmde_pkg::RECIP100);
      p1000 = 29'(mv) * 29'(bmde_pkg::RECIP1000);
      q10   = p10[29:19];
      q100  = p100[26:19];
      q1000 = p1000[28:24];
      rem = 4'(mv - 14'(q10) * 14'd10);
      r0  = 4'(q10 - 11'(q100) * 11'd10);
      m0  = 4'(q100 - 8'(q1000) * 8'd10);
      l0  = (q1000 >= 5'd10) ? 4'(q1000 - 5'd10) : q1000[3:0];

      // round up on a dropped digit above five, ripple the carry
      r1      = r0 + ((rem > 4'd5) ? 4'd1 : 4'd0);
      carry_r = (r1 == 4'd10);
      vr      = carry_r ? 4'd0 : r1;
      m1      = m0 + (carry_r ? 4'd1 : 4'd0);
      carry_m = (m1 == 4'd10);
      vm      = carry_m ? 4'd0 : m1;
      l1      = l0 + (carry_m ? 4'd1 : 4'd0);
      vl      = (l1 == 4'd10) ? 4'd0 : l1;

      // percent, clamped
      over    = mv - bmde_pkg::MV_OFFSET;
      over_sh = over[13:3];
      if (mv < bmde_pkg::MV_OFFSET) begin
         pct = 7'd0;
      end else if (over_sh > 11'(bmde_pkg::PCT_MAX)) begin
         pct = bmde_pkg::PCT_MAX;
      end else begin
         pct = over_sh[6:0];
      end
      pq = 15'(pct) * 15'(bmde_pkg::RECIP10_PCT);
      pt = pq[14:11];
      pr = 4'(pct - 7'(pt) * 7'd10);
      pl = (pt >= 4'd10);
      pm = pl ? 4'd0 : pt;

      disp = '0;
      if (item_i.status_byte[bmde_pkg::PCT_MODE_BIT]) begin
         disp[bmde_pkg::MARK_PCT] = 1'b1;
         if (pl) begin
            disp[bmde_pkg::DIGIT_L_LSB +: 7] = bmde_pkg::seg7(4'd1);
         end
         if (pl || pm != 4'd0) begin
            disp[bmde_pkg::DIGIT_M_LSB +: 7] = bmde_pkg::seg7(pm);
         end
         disp[bmde_pkg::DIGIT_R_LSB +: 7] = bmde_pkg::seg7(pr);
      end else begin
         disp[bmde_pkg::MARK_VOLT] = 1'b1;
         disp[bmde_pkg::MARK_DP]   = 1'b1;
         disp[bmde_pkg::DIGIT_L_LSB +: 7] = bmde_pkg::seg7(vl);
         disp[bmde_pkg::DIGIT_M_LSB +: 7] = bmde_pkg::seg7(vm);
         disp[bmde_pkg::DIGIT_R_LSB +: 7] = bmde_pkg::seg7(vr);
      end
      disp[bmde_pkg::BAR_LSB + 0] = (pct > bmde_pkg::BAR_TH0);
      disp[bmde_pkg::BAR_LSB + 1] = (pct > bmde_pkg::BAR_TH1);
      disp[bmde_pkg::BAR_LSB + 2] = (pct > bmde_pkg::BAR_TH2);
      disp[bmde_pkg::BAR_LSB + 3] = (pct > bmde_pkg::BAR_TH3);
      disp[bmde_pkg::BAR_LSB + 4] = (pct > bmde_pkg::BAR_TH4);

      // negative sample: miswired sensor, blank word
      if (item_i.voltage_raw[15]) begin
         item_o.display_bits = '0;
         item_o.error        = 1'b1;
      end else begin
         item_o.display_bits = disp;
         item_o.error        = 1'b0;
      end
   end

endmodule

FILE: rtl/battery_meter_display_encoder.sv
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+---------------------------
// request   | start, busy, req_item          | item taken when start && !busy
// response  | rsp_valid, rsp_item            | one-cycle strobe, no back-pressure
//
// One item per cycle; busy never rises. Each item is captured in the input
// register, encoded by the reciprocal-multiply digit logic and captured in
// the result register, whose strobe lasts one cycle.
// Synchronous reset clears both valid flags; items in flight are dropped.

`include "battery_meter_display_encoder_macros.svh"

module battery_meter_display_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bmde_pkg::req_type  req_item,
   output logic               rsp_valid,
   output bmde_pkg::rsp_type  rsp_item
);

   logic              in_valid_ff, in_valid_in;
   bmde_pkg::req_type in_item_ff;
   logic              out_valid_ff, out_valid_in;
   bmde_pkg::rsp_type out_item_ff, out_item_in;

   assign busy         = 1'b0;
   assign in_valid_in  = start && !busy;
   assign out_valid_in = in_valid_ff;

   bmde_encode u_encode (
      .item_i (in_item_ff),
      .item_o (out_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) begin
         in_item_ff <= req_item;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `BMDE_ASSERT_NEXT(a_stage_fwd, clock, reset, in_valid_ff, rsp_valid)
   `BMDE_ASSERT_NEXT(a_no_phantom, clock, reset, !in_valid_ff, !rsp_valid)
   `BMDE_ASSERT_NOW(a_err_blank, clock, reset, rsp_valid && rsp_item.error, rsp_item.display_bits == 29'd0)
   `BMDE_ASSERT_NOW(a_one_mode, clock, reset, rsp_valid && !rsp_item.error, rsp_item.display_bits[0] != rsp_item.display_bits[1])

endmodule
